@@ hdl/wtns_pkg.sv @@
`timescale 1ns / 1ps
package wtns_pkg;

   localparam int unsigned Q16_ONE = 65536;
   localparam int unsigned REC_SAT = 15;

   // Configuration register indexes.
   localparam logic [2:0] CSR_PRESSURE_LIMIT  = 3'd0;
   localparam logic [2:0] CSR_BANDWIDTH_LIMIT = 3'd1;
   localparam logic [2:0] CSR_DISTANCE_WEIGHT = 3'd2;
   localparam logic [2:0] CSR_PRESSURE_WEIGHT = 3'd3;
   localparam logic [2:0] CSR_BW_WEIGHT       = 3'd4;
   localparam logic [2:0] CSR_WEIGHTED_MODE   = 3'd5;

   localparam logic ACTION_START  = 1'b0;
   localparam logic ACTION_RECORD = 1'b1;

   typedef struct packed {
      logic        action;
      logic [39:0] object_bytes;
      logic [2:0]  home_node;
      logic [2:0]  node_index;
      logic [7:0]  node_distance;
      logic [16:0] pressure_q16;
      logic [47:0] free_bytes;
      logic [16:0] bandwidth_q16;
      logic        last_record;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [2:0] target_node;
   } rsp_type;

   // One stored candidate: node, distance, pressure, bandwidth.
   typedef struct packed {
      logic [2:0]  node;
      logic [7:0]  distance;
      logic [16:0] pressure;
      logic [16:0] bandwidth;
   } cand_type;

endpackage

@@ hdl/wtns_ram.sv @@
`timescale 1ns / 1ps
module wtns_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Single write port, registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ hdl/wtns_div.sv @@
`timescale 1ns / 1ps
// Restoring divider: 33-bit dividend (value << 16), 17-bit divisor, one quotient bit
// per cycle. Quotient fits in 33 bits.
module wtns_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [32:0] dividend,
   input  logic [16:0] divisor,
   output logic        done,
   output logic [32:0] quotient
);

   logic [32:0] quot_ff, quot_in;
   logic [17:0] rem_ff, rem_in;
   logic [16:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [17:0] trial;
   logic [18:0] diff;

   assign trial = {rem_ff[16:0], quot_ff[32]};
   assign diff  = {1'b0, trial} - {2'b00, dvs_ff};

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = 6'd33;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // Shift one dividend bit into the remainder and try a subtract.
         if (!diff[18]) begin
            rem_in  = diff[17:0];
            quot_in = {quot_ff[31:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[31:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

@@ hdl/weighted_target_node_selector.sv @@
`timescale 1ns / 1ps
// Weighted target node selector.
// The request channel (req_valid, req_stall, req_payload) carries start
// transactions, which latch the object size and home node, and node record
// transactions. Records that pass the home, pressure, bandwidth and free
// space tests are written into the candidate memory while it has room. Start
// and non-last record transactions are taken one per cycle, back to back.
// The record marked last triggers a scoring pass: each candidate is read
// back, its three ratios to the tracked maxima are formed by one shared
// serial divider, scored and compared, and req_stall stays high from the
// last record until the response is loaded.
// Exactly one response transaction (rsp_valid, rsp_stall, rsp_payload) is
// produced per last record; found is 0 with fewer than two records or no
// candidate. The response is held in an output register while rsp_stall is
// high, and new requests are taken meanwhile; the next decision waits for
// it to leave. Configuration writes on csr_* belong between transactions.
// A synchronous reset restores register defaults and clears the
// collection; the candidate memory needs no clearing.
module weighted_target_node_selector #(
   parameter int MAX_NODES = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  wtns_pkg::req_type       req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output wtns_pkg::rsp_type       rsp_payload,
   input  logic                    csr_write_en,
   input  logic [2:0]              csr_index,
   input  logic [6:0]              csr_data
);

   import wtns_pkg::*;

   localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CW = $clog2(MAX_NODES + 1);
   localparam int CANDW = $bits(cand_type);

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_DIV, ST_SCORE, ST_NEXT, ST_OUT
   } state_type;

   // Configuration registers.
   logic [6:0] p_lim_ff, b_lim_ff, d_wt_ff, p_wt_ff, b_wt_ff;
   logic       mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_lim_ff <= 7'd80;
         b_lim_ff <= 7'd90;
         d_wt_ff  <= 7'd50;
         p_wt_ff  <= 7'd30;
         b_wt_ff  <= 7'd20;
         mode_ff  <= 1'b1;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_PRESSURE_LIMIT:  p_lim_ff <= csr_data;
            CSR_BANDWIDTH_LIMIT: b_lim_ff <= csr_data;
            CSR_DISTANCE_WEIGHT: d_wt_ff  <= csr_data;
            CSR_PRESSURE_WEIGHT: p_wt_ff  <= csr_data;
            CSR_BW_WEIGHT:       b_wt_ff  <= csr_data;
            CSR_WEIGHTED_MODE:   mode_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Control and collection state.
   state_type   state_ff;
   logic [CW-1:0] cnt_ff;
   logic [3:0]  seen_ff;
   logic [7:0]  maxd_ff;
   logic [16:0] maxp_ff, maxb_ff;
   logic [39:0] size_ff;
   logic [2:0]  home_ff;
   logic [CW-1:0] k_ff;
   logic [1:0]  ratio_ff;
   logic [16:0] md_ff, mp_ff, mb_ff;
   logic [39:0] score_ff, best_score_ff;
   logic [2:0]  lead_node_ff;
   logic        div_go_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   rsp_type     pick_ff;

   // Record filtering.
   logic        accept;
   logic        surv;
   logic [23:0] p_x100, b_x100, p_lim_q, b_lim_q;
   logic [23:0] maxp_x100, maxb_x100;

   assign accept = req_valid && !req_stall;
   assign p_x100 = 24'(req_payload.pressure_q16) * 24'd100;
   assign b_x100 = 24'(req_payload.bandwidth_q16) * 24'd100;
   assign p_lim_q = {1'b0, p_lim_ff, 16'd0};
   assign b_lim_q = {1'b0, b_lim_ff, 16'd0};
   assign surv = (req_payload.node_index != home_ff) && (p_x100 < p_lim_q)
      && (b_x100 < b_lim_q) && (req_payload.free_bytes >= {7'd0, size_ff, 1'b0});
   assign maxp_x100 = 24'(maxp_ff) * 24'd100;
   assign maxb_x100 = 24'(maxb_ff) * 24'd100;

   // Candidate memory.
   logic         wr_en;
   cand_type     wr_cand, rd_cand;
   logic [CANDW-1:0] rd_raw;
   assign wr_en = accept && req_payload.action == ACTION_RECORD && surv
      && cnt_ff < CW'(MAX_NODES);
   assign wr_cand = '{node: req_payload.node_index, distance: req_payload.node_distance,
      pressure: req_payload.pressure_q16, bandwidth: req_payload.bandwidth_q16};
   assign rd_cand = cand_type'(rd_raw);

   wtns_ram #(.WIDTH(CANDW), .DEPTH(MAX_NODES)) u_cand (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data (wr_cand),
      .rd_addr (k_ff[AW-1:0]),
      .rd_data (rd_raw)
   );

   // Shared divider.
   logic [32:0] div_dividend, div_q;
   logic [16:0] div_divisor;
   logic        div_done;
   cand_type    cur_ff;
   always_comb begin
      case (ratio_ff)
         2'd0: begin
            div_dividend = {9'd0, cur_ff.distance, 16'd0};
            div_divisor  = md_ff;
         end
         2'd1: begin
            div_dividend = {cur_ff.pressure, 16'd0};
            div_divisor  = mp_ff;
         end
         default: begin
            div_dividend = {cur_ff.bandwidth, 16'd0};
            div_divisor  = mb_ff;
         end
      endcase
   end

   wtns_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_ff),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Score products: one weighted product per divider result in weighted mode, the plain ratio otherwise.
   logic [31:0] prod;
   logic [6:0]  wsel;
   always_comb begin
      case (ratio_ff)
         2'd0:    wsel = d_wt_ff;
         2'd1:    wsel = p_wt_ff;
         default: wsel = b_wt_ff;
      endcase
      prod = mode_ff ? 32'(div_q) * 32'(wsel) : 32'(div_q);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         seen_ff      <= '0;
         maxd_ff      <= '0;
         maxp_ff      <= '0;
         maxb_ff      <= '0;
         size_ff      <= '0;
         home_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         div_go_ff    <= 1'b0;
         k_ff         <= '0;
         ratio_ff     <= '0;
      end else begin
         div_go_ff <= 1'b0;
         // The output register loads a decision once the previous one has left.
         if (state_ff == ST_OUT && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept && req_payload.action == ACTION_START) begin
                  size_ff <= req_payload.object_bytes;
                  home_ff <= req_payload.home_node;
                  cnt_ff  <= '0;
                  seen_ff <= '0;
                  maxd_ff <= '0;
                  maxp_ff <= '0;
                  maxb_ff <= '0;
               end else if (accept) begin
                  if (seen_ff < 4'(REC_SAT)) seen_ff <= seen_ff + 4'd1;
                  if (wr_en) begin
                     cnt_ff <= cnt_ff + CW'(1);
                     if (req_payload.node_distance > maxd_ff)
                        maxd_ff <= req_payload.node_distance;
                     if (req_payload.pressure_q16 > maxp_ff)
                        maxp_ff <= req_payload.pressure_q16;
                     if (req_payload.bandwidth_q16 > maxb_ff)
                        maxb_ff <= req_payload.bandwidth_q16;
                  end
                  if (req_payload.last_record) begin
                     k_ff     <= '0;
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_READ: begin
               // Maxima and counts are final now; pick divisors while entry k is read.
               if (seen_ff < 4'd2 || cnt_ff == '0) begin
                  pick_ff  <= '{found: 1'b0, target_node: 3'd0};
                  state_ff <= ST_OUT;
               end else begin
                  md_ff    <= (maxd_ff == 8'd0) ? 17'd1 : {9'd0, maxd_ff};
                  mp_ff    <= (maxp_x100 < 24'(Q16_ONE)) ? 17'(Q16_ONE) : maxp_ff;
                  mb_ff    <= (maxb_x100 < 24'(Q16_ONE)) ? 17'(Q16_ONE) : maxb_ff;
                  state_ff <= ST_NEXT;
               end
            end
            ST_NEXT: begin
               // Memory data for entry k arrives this cycle.
               cur_ff    <= rd_cand;
               ratio_ff  <= 2'd0;
               score_ff  <= '0;
               div_go_ff <= 1'b1;
               state_ff  <= ST_DIV;
            end
            ST_DIV: begin
               if (div_done) begin
                  score_ff <= score_ff + 40'(prod);
                  if (ratio_ff == 2'd2) begin
                     state_ff <= ST_SCORE;
                  end else begin
                     ratio_ff  <= ratio_ff + 2'd1;
                     div_go_ff <= 1'b1;
                  end
               end
            end
            ST_SCORE: begin
               if (k_ff == '0 || score_ff < best_score_ff) begin
                  best_score_ff <= score_ff;
                  lead_node_ff  <= cur_ff.node;
               end
               if (k_ff + CW'(1) >= cnt_ff) begin
                  pick_ff  <= '{found: 1'b1,
                     target_node: (k_ff == '0 || score_ff < best_score_ff)
                        ? cur_ff.node : lead_node_ff};
                  state_ff <= ST_OUT;
               end else begin
                  // Go back through the read state so the next entry is fetched.
                  k_ff     <= k_ff + CW'(1);
                  state_ff <= ST_READ;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ff   <= pick_ff;
                  cnt_ff   <= '0;
                  seen_ff  <= '0;
                  maxd_ff  <= '0;
                  maxp_ff  <= '0;
                  maxb_ff  <= '0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
